FILE: sv/ndag_pkg.sv
package ndag_pkg;

  // configuration port
  localparam int CFG_W     = 64;
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_AXIS_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ITER_SIZES = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STOR_SIZES = 2'd2;
  localparam int AXIS_COUNT_W = 3;

  // request fields
  localparam int AXIS_W = 3;
  localparam logic KIND_EMIT    = 1'b0;
  localparam logic KIND_RESTART = 1'b1;

  // command queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  typedef struct packed {
    logic              restart;
    logic              exhaust;
    logic [AXIS_W-1:0] axis;
  } cmd_t;

endpackage

FILE: sv/ndag_if.sv
interface ndag_in_if;
  logic                                valid;
  logic                                ready;
  logic                                kind;
  logic signed [ndag_pkg::AXIS_W-1:0]  advance_axis;

  modport source (output valid, kind, advance_axis, input ready);
  modport sink   (input valid, kind, advance_axis, output ready);
endinterface

interface ndag_out_if #(parameter int ADDR_BITS = 32);
  logic                 valid;
  logic                 ready;
  logic [ADDR_BITS-1:0] address;
  logic                 position_valid;
  logic                 exhausted_after;

  modport source (output valid, address, position_valid, exhausted_after, input ready);
  modport sink   (input valid, address, position_valid, exhausted_after, output ready);
endinterface

FILE: sv/ndag_front.sv
module ndag_front #(
  parameter int NW = 3
) (
  input  logic           clk,
  input  logic           rst_n,
  ndag_in_if.sink        in_req,
  input  logic [NW-1:0]  axes_n,
  output ndag_pkg::cmd_t push_cmd,
  output logic           push_vld,
  input  logic           push_rdy
);
  import ndag_pkg::*;

  localparam int CMP_W = ((NW > AXIS_W) ? NW : AXIS_W) + 1;

  cmd_t             cmd_r, cmd_nxt;
  logic             vld_r, vld_nxt;
  logic             neg;
  logic [CMP_W-1:0] adv_u;
  logic [CMP_W-1:0] last_ax;
  logic [CMP_W-1:0] axis_sel;
  logic             take;

  assign in_req.ready = !vld_r || push_rdy;
  assign take         = in_req.valid && in_req.ready;

  // classify: restart, forced exhaustion, or advance clamped to innermost axis
  always_comb begin
    neg      = in_req.advance_axis[AXIS_W-1];
    adv_u    = CMP_W'($unsigned(in_req.advance_axis));
    last_ax  = CMP_W'(axes_n) - CMP_W'(1);
    axis_sel = (adv_u >= CMP_W'(axes_n)) ? last_ax : adv_u;

    cmd_nxt = cmd_r;
    vld_nxt = vld_r && !push_rdy;
    if (take) begin
      cmd_nxt.restart = (in_req.kind == KIND_RESTART);
      cmd_nxt.exhaust = neg;
      cmd_nxt.axis    = AXIS_W'(axis_sel);
      vld_nxt         = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
    cmd_r <= cmd_nxt;
  end

  assign push_cmd = cmd_r;
  assign push_vld = vld_r;

endmodule

FILE: sv/ndag_cmdq.sv
module ndag_cmdq (
  input  logic           clk,
  input  logic           rst_n,
  input  ndag_pkg::cmd_t push_cmd,
  input  logic           push_vld,
  output logic           push_rdy,
  output ndag_pkg::cmd_t q_cmd,
  output logic           q_vld,
  input  logic           q_pop
);
  import ndag_pkg::*;

  cmd_t              slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              push;
  logic              pop;

  assign push_rdy = (count_r != QCNT_W'(QUEUE_DEPTH));
  assign q_vld    = (count_r != '0);
  assign q_cmd    = slot_r[rd_ptr_r];
  assign push     = push_vld && push_rdy;
  assign pop      = q_pop && q_vld;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + QCNT_W'(push) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

FILE: sv/ndag_back.sv
module ndag_back #(
  parameter int MAX_AXES  = 4,
  parameter int SIZE_BITS = 16,
  parameter int ADDR_BITS = 32,
  parameter int NW        = 3,
  parameter int AX_W      = 2
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  ndag_pkg::cmd_t                     q_cmd,
  input  logic                               q_vld,
  output logic                               q_pop,
  input  logic [NW-1:0]                      axes_n,
  input  logic [MAX_AXES-1:0][SIZE_BITS-1:0] iter_sz,
  input  logic [MAX_AXES-1:0][SIZE_BITS-1:0] stor_sz,
  ndag_out_if.source                         out_res
);
  import ndag_pkg::*;

  localparam int CNT_W = SIZE_BITS + 1;
  localparam int WW    = CNT_W + 1;

  typedef enum logic [1:0] {S_IDLE, S_MAC, S_ADV, S_DONE} state_t;

  state_t                state_r, state_nxt;
  cmd_t                  cmd_r, cmd_nxt;
  logic [AX_W-1:0]       idx_r, idx_nxt;
  logic [ADDR_BITS-1:0]  acc_r, acc_nxt;
  logic                  pv_r, pv_nxt;
  logic [CNT_W-1:0]      cnt_r [MAX_AXES];
  logic [CNT_W-1:0]      cnt_nxt [MAX_AXES];
  logic                  out_vld_r, out_vld_nxt;
  logic [ADDR_BITS-1:0]  addr_o_r, addr_o_nxt;
  logic                  pvo_r, pvo_nxt;
  logic                  exh_r, exh_nxt;

  logic                  ok_now;
  logic                  exh0;
  logic [MAX_AXES-1:0]   wrap;
  logic [CNT_W-1:0]      adv_cnt [MAX_AXES];
  logic                  carry;
  logic [CNT_W-1:0]      cur_cnt;
  logic [SIZE_BITS-1:0]  cur_st;
  logic [ADDR_BITS-1:0]  st_ext;
  logic [ADDR_BITS-1:0]  idx_val;
  logic [ADDR_BITS-1:0]  mac_val;
  logic                  last_axis;

  // every axis in use below its iteration size
  always_comb begin
    ok_now = 1'b1;
    for (int i = 0; i < MAX_AXES; i++) begin
      if ((i < int'(axes_n)) && (cnt_r[i] >= CNT_W'(iter_sz[i]))) begin
        ok_now = 1'b0;
      end
    end
  end

  // odometer step, carry runs from the chosen axis toward axis 0
  always_comb begin
    exh0 = (cnt_r[0] >= CNT_W'(iter_sz[0]));
    for (int i = 0; i < MAX_AXES; i++) begin
      wrap[i] = ((WW'(cnt_r[i]) + WW'(1)) >= WW'(iter_sz[i]));
    end
    adv_cnt = cnt_r;
    carry   = 1'b1;
    if (cmd_r.exhaust) begin
      adv_cnt[0] = CNT_W'(iter_sz[0]) + CNT_W'(1);
    end else if (!exh0) begin
      for (int i = MAX_AXES - 1; i >= 0; i--) begin
        if (carry && (i <= int'(cmd_r.axis))) begin
          if ((i != 0) && wrap[i]) begin
            adv_cnt[i] = '0;
          end else begin
            adv_cnt[i] = cnt_r[i] + CNT_W'(1);
            carry      = 1'b0;
          end
        end
      end
    end
  end

  // one axis per cycle: acc = acc * storage size + broadcast index
  always_comb begin
    cur_cnt   = cnt_r[idx_r];
    cur_st    = stor_sz[idx_r];
    st_ext    = ADDR_BITS'(cur_st);
    idx_val   = (cur_cnt >= CNT_W'(cur_st)) ? '0 : ADDR_BITS'(cur_cnt);
    mac_val   = (idx_r == '0) ? idx_val : (acc_r * st_ext) + idx_val;
    last_axis = ((NW'(idx_r) + NW'(1)) == axes_n);
  end

  always_comb begin
    state_nxt   = state_r;
    cmd_nxt     = cmd_r;
    idx_nxt     = idx_r;
    acc_nxt     = acc_r;
    pv_nxt      = pv_r;
    cnt_nxt     = cnt_r;
    out_vld_nxt = out_vld_r && !out_res.ready;
    addr_o_nxt  = addr_o_r;
    pvo_nxt     = pvo_r;
    exh_nxt     = exh_r;
    q_pop       = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (q_vld) begin
          q_pop   = 1'b1;
          cmd_nxt = q_cmd;
          if (q_cmd.restart) begin
            for (int i = 0; i < MAX_AXES; i++) begin
              cnt_nxt[i] = '0;
            end
            acc_nxt   = '0;
            pv_nxt    = 1'b0;
            state_nxt = S_DONE;
          end else begin
            idx_nxt   = '0;
            state_nxt = S_MAC;
          end
        end
      end
      S_MAC: begin
        acc_nxt = mac_val;
        if (last_axis) begin
          state_nxt = S_ADV;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_ADV: begin
        pv_nxt    = ok_now;
        cnt_nxt   = adv_cnt;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_vld_r || out_res.ready) begin
          out_vld_nxt = 1'b1;
          addr_o_nxt  = acc_r;
          pvo_nxt     = pv_r;
          exh_nxt     = !ok_now;
          state_nxt   = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      out_vld_r <= 1'b0;
      for (int i = 0; i < MAX_AXES; i++) begin
        cnt_r[i] <= '0;
      end
    end else begin
      state_r   <= state_nxt;
      out_vld_r <= out_vld_nxt;
      cnt_r     <= cnt_nxt;
    end
    cmd_r    <= cmd_nxt;
    idx_r    <= idx_nxt;
    acc_r    <= acc_nxt;
    pv_r     <= pv_nxt;
    addr_o_r <= addr_o_nxt;
    pvo_r    <= pvo_nxt;
    exh_r    <= exh_nxt;
  end

  assign out_res.valid           = out_vld_r;
  assign out_res.address         = addr_o_r;
  assign out_res.position_valid  = pvo_r;
  assign out_res.exhausted_after = exh_r;

`ifndef SYNTHESIS
  a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && out_vld_r && !out_res.ready) |=> (state_r == S_DONE))
    else $error("result slot overwritten while a result is pending");

  a_restart_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && q_vld && q_cmd.restart) |=>
      (state_r == S_DONE && acc_r == '0 && !pv_r))
    else $error("restart did not produce a zero address");

  a_mac_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MAC) |-> (NW'(idx_r) < axes_n))
    else $error("address walk past the last axis in use");

  a_forced_exhaust: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ADV && cmd_r.exhaust) |=> (cnt_r[0] > CNT_W'(iter_sz[0])))
    else $error("negative axis did not exhaust axis 0");
`endif

endmodule

FILE: sv/nd_address_generator_unit.sv
// N-dimensional address generator with broadcast. Each emit request returns
// the row-major address of the current position over the storage sizes
// (an axis whose counter is at or past its storage size contributes index 0),
// whether that position was inside the iteration sizes, and whether the
// position after the odometer advance is exhausted. A restart request clears
// all axis counters. Requests are decoded and queued up to three deep, so the
// input keeps flowing while the address unit works. The address is built by
// one shared multiply-add unit, one axis per cycle, so an emit request steps
// through pop, one multiply-add per axis, advance and result, and a restart
// through pop and result. Results sit in an output register, so a stalled consumer
// only holds the next result. Write configuration only while the block is idle.
module nd_address_generator_unit #(
  parameter int MAX_AXES  = 4,
  parameter int SIZE_BITS = 16,
  parameter int ADDR_BITS = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [ndag_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ndag_pkg::CFG_W-1:0]       cfg_data,
  ndag_in_if.sink                          in_req,
  ndag_out_if.source                       out_res
);
  import ndag_pkg::*;

  localparam int NW   = $clog2(MAX_AXES + 1);
  localparam int AX_W = (MAX_AXES > 1) ? $clog2(MAX_AXES) : 1;

  logic [AXIS_COUNT_W-1:0]            axis_count_r;
  logic [CFG_W-1:0]                   iter_sizes_r;
  logic [CFG_W-1:0]                   stor_sizes_r;
  logic [NW-1:0]                      axes_n;
  logic [CFG_W+SIZE_BITS-1:0]         iter_ext;
  logic [CFG_W+SIZE_BITS-1:0]         stor_ext;
  logic [MAX_AXES-1:0][SIZE_BITS-1:0] iter_sz;
  logic [MAX_AXES-1:0][SIZE_BITS-1:0] stor_sz;

  cmd_t push_cmd;
  logic push_vld;
  logic push_rdy;
  cmd_t q_cmd;
  logic q_vld;
  logic q_pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      axis_count_r <= AXIS_COUNT_W'(1);
      iter_sizes_r <= '0;
      stor_sizes_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_AXIS_COUNT: axis_count_r <= cfg_data[AXIS_COUNT_W-1:0];
        CFG_ITER_SIZES: iter_sizes_r <= cfg_data;
        CFG_STOR_SIZES: stor_sizes_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // zero and oversized axis counts clamp into range
  always_comb begin
    if (axis_count_r == '0) begin
      axes_n = NW'(1);
    end else if (int'(axis_count_r) > MAX_AXES) begin
      axes_n = NW'(MAX_AXES);
    end else begin
      axes_n = NW'(axis_count_r);
    end
  end

  // fields lying past bit 63 read as zero
  assign iter_ext = {{SIZE_BITS{1'b0}}, iter_sizes_r};
  assign stor_ext = {{SIZE_BITS{1'b0}}, stor_sizes_r};

  for (genvar g = 0; g < MAX_AXES; g++) begin : g_size
    if (SIZE_BITS * g < CFG_W) begin : g_in
      assign iter_sz[g] = iter_ext[SIZE_BITS*g +: SIZE_BITS];
      assign stor_sz[g] = stor_ext[SIZE_BITS*g +: SIZE_BITS];
    end else begin : g_out
      assign iter_sz[g] = '0;
      assign stor_sz[g] = '0;
    end
  end

  ndag_front #(
    .NW (NW)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_req   (in_req),
    .axes_n   (axes_n),
    .push_cmd (push_cmd),
    .push_vld (push_vld),
    .push_rdy (push_rdy)
  );

  ndag_cmdq u_cmdq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push_cmd (push_cmd),
    .push_vld (push_vld),
    .push_rdy (push_rdy),
    .q_cmd    (q_cmd),
    .q_vld    (q_vld),
    .q_pop    (q_pop)
  );

  ndag_back #(
    .MAX_AXES  (MAX_AXES),
    .SIZE_BITS (SIZE_BITS),
    .ADDR_BITS (ADDR_BITS),
    .NW        (NW),
    .AX_W      (AX_W)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_cmd   (q_cmd),
    .q_vld   (q_vld),
    .q_pop   (q_pop),
    .axes_n  (axes_n),
    .iter_sz (iter_sz),
    .stor_sz (stor_sz),
    .out_res (out_res)
  );

endmodule

FILE: verif/nd_address_generator_unit_test.sv
module nd_address_generator_unit_test;
  import ndag_pkg::*;

  localparam int NUM_AXES     = 4;
  localparam int SZ_W         = 16;
  localparam int ADDR_W       = 32;
  localparam int RANDOM_ITEMS = 600;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 16;
  localparam int IDLE_PCT     = 27;
  localparam int NUM_ROWS     = 32;
  localparam logic [AXIS_W-1:0] AXIS_EXHAUST = 3'b111;

  typedef struct packed {
    logic [ADDR_W-1:0] address;
    logic              position_valid;
    logic              exhausted_after;
  } walk_result_t;

  typedef struct packed {
    logic                 is_cfg;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_value;
    logic                 kind;
    logic [AXIS_W-1:0]    axis;
    logic                 typed;
    walk_result_t         result;
  } stim_row_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  ndag_in_if                       req_ch ();
  ndag_out_if #(.ADDR_BITS(ADDR_W)) res_ch ();

  nd_address_generator_unit #(
    .MAX_AXES (NUM_AXES),
    .SIZE_BITS(SZ_W),
    .ADDR_BITS(ADDR_W)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_req   (req_ch),
    .out_res  (res_ch)
  );

  // shadow of the block's registers and counters
  logic [AXIS_COUNT_W-1:0] axes_reg;
  logic [CFG_W-1:0]        iter_reg;
  logic [CFG_W-1:0]        stor_reg;
  logic [SZ_W:0]           cnt_reg [NUM_AXES];

  walk_result_t expected_results [$];
  int           mismatches;
  int           cycles;
  bit           steady;

  function automatic stim_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                        input logic [CFG_W-1:0] value);
    stim_row_t r;
    r = '0;
    r.is_cfg    = 1'b1;
    r.cfg_index = idx;
    r.cfg_value = value;
    return r;
  endfunction

  function automatic stim_row_t req_row(input logic kind, input logic [AXIS_W-1:0] axis);
    stim_row_t r;
    r = '0;
    r.kind = kind;
    r.axis = axis;
    return r;
  endfunction

  function automatic stim_row_t checked_row(input logic kind, input logic [AXIS_W-1:0] axis,
                                            input logic [ADDR_W-1:0] address,
                                            input logic pv, input logic ex);
    stim_row_t r;
    r = req_row(kind, axis);
    r.typed  = 1'b1;
    r.result = '{address, pv, ex};
    return r;
  endfunction

  localparam stim_row_t DIRECTED_ROWS [NUM_ROWS] = '{
    // after reset every size is zero, so the walk is exhausted at once
    checked_row(KIND_EMIT, 3'd0, 32'd0, 1'b0, 1'b1),
    checked_row(KIND_RESTART, 3'd0, 32'd0, 1'b0, 1'b1),
    cfg_row(CFG_AXIS_COUNT, 64'd4),
    cfg_row(CFG_ITER_SIZES, {CFG_W{1'b1}}),
    cfg_row(CFG_STOR_SIZES, {CFG_W{1'b1}}),
    checked_row(KIND_RESTART, 3'd0, 32'd0, 1'b0, 1'b0),
    checked_row(KIND_EMIT, 3'd3, 32'd0, 1'b1, 1'b0),
    checked_row(KIND_EMIT, 3'd3, 32'd1, 1'b1, 1'b0),
    checked_row(KIND_EMIT, AXIS_EXHAUST, 32'd2, 1'b1, 1'b1),
    // counter 0 now past its size: broadcast on axis 0, no advance
    checked_row(KIND_EMIT, 3'd2, 32'd2, 1'b0, 1'b1),
    req_row(KIND_EMIT, 3'b100),
    req_row(KIND_RESTART, 3'd0),
    req_row(KIND_EMIT, 3'b101),
    req_row(KIND_RESTART, 3'd7),
    cfg_row(CFG_AXIS_COUNT, 64'd3),
    cfg_row(CFG_ITER_SIZES, 64'h0005_0002_0003_0002),
    cfg_row(CFG_STOR_SIZES, 64'h0004_0000_0001_0002),
    req_row(KIND_RESTART, 3'd0),
    // axis 3 beyond the axis count acts as the innermost axis
    req_row(KIND_EMIT, 3'd3),
    req_row(KIND_EMIT, 3'd3),
    req_row(KIND_EMIT, 3'd3),
    req_row(KIND_EMIT, 3'd3),
    req_row(KIND_EMIT, 3'd3),
    req_row(KIND_EMIT, 3'd3),
    req_row(KIND_EMIT, 3'd3),
    req_row(KIND_EMIT, 3'd3),
    req_row(KIND_EMIT, 3'd1),
    req_row(KIND_EMIT, 3'd0),
    req_row(KIND_EMIT, 3'b110),
    cfg_row(CFG_AXIS_COUNT, 64'd0),
    req_row(KIND_RESTART, 3'd0),
    req_row(KIND_EMIT, 3'd0)
  };

  function automatic logic [SZ_W:0] size_field(input logic [CFG_W-1:0] packed_sizes,
                                                input int ax);
    return {1'b0, packed_sizes[SZ_W*ax +: SZ_W]};
  endfunction

  function automatic int axes_in_use();
    if (axes_reg == 0) return 1;
    if (axes_reg > NUM_AXES) return NUM_AXES;
    return int'(axes_reg);
  endfunction

  function automatic logic walk_inside(input int n);
    int i;
    for (i = 0; i < n; i++) begin
      if (cnt_reg[i] >= size_field(iter_reg, i)) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic walk_result_t predict_walk(input logic kind,
                                                input logic [AXIS_W-1:0] axis_bits);
    walk_result_t r;
    int           n;
    int           ax;
    int           i;
    logic [63:0]  acc;
    logic [SZ_W:0] st;
    logic [SZ_W:0] idx;
    bit           carry;
    n  = axes_in_use();
    ax = $signed(axis_bits);
    if (kind == KIND_RESTART) begin
      for (i = 0; i < NUM_AXES; i++) cnt_reg[i] = '0;
      r.address         = '0;
      r.position_valid  = 1'b0;
      r.exhausted_after = !walk_inside(n);
      return r;
    end
    acc = '0;
    for (i = 0; i < n; i++) begin
      st  = size_field(stor_reg, i);
      idx = (cnt_reg[i] >= st) ? '0 : cnt_reg[i];
      if (i > 0) acc = acc * st;
      acc = (acc + idx) & 64'hFFFF_FFFF;
    end
    r.address        = acc[ADDR_W-1:0];
    r.position_valid = walk_inside(n);
    if (ax < 0) begin
      cnt_reg[0] = size_field(iter_reg, 0) + 1'b1;
    end else if (cnt_reg[0] < size_field(iter_reg, 0)) begin
      if (ax > n - 1) ax = n - 1;
      carry = 1'b1;
      for (i = ax; i >= 0 && carry; i--) begin
        // inner axes wrap, axis 0 keeps counting
        if (i != 0 && ({1'b0, cnt_reg[i]} + 1'b1) >= {1'b0, size_field(iter_reg, i)}) begin
          cnt_reg[i] = '0;
        end else begin
          cnt_reg[i] = cnt_reg[i] + 1'b1;
          carry      = 1'b0;
        end
      end
    end
    r.exhausted_after = !walk_inside(n);
    return r;
  endfunction

  task automatic set_register(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_AXIS_COUNT: axes_reg = value[AXIS_COUNT_W-1:0];
      CFG_ITER_SIZES: iter_reg = value;
      CFG_STOR_SIZES: stor_reg = value;
      default: ;
    endcase
  endtask

  task automatic drain();
    req_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic issue(input logic kind, input logic [AXIS_W-1:0] axis,
                       input logic typed, input walk_result_t typed_res);
    walk_result_t predicted;
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid        <= 1'b1;
    req_ch.kind         <= kind;
    req_ch.advance_axis <= axis;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    predicted = predict_walk(kind, axis);
    expected_results.push_back(typed ? typed_res : predicted);
  endtask

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("timeout after %0d cycles, %0d results outstanding", cycles,
             expected_results.size());
    $display("nd_address_generator_unit_test: done, errors");
    $finish;
  end

  // result side: check every accepted result against the oldest prediction
  initial begin
    walk_result_t want;
    walk_result_t got;
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && res_ch.valid && res_ch.ready) begin
        got = '{res_ch.address, res_ch.position_valid, res_ch.exhausted_after};
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: address %h position_valid %b exhausted_after %b",
                     got.address, got.position_valid, got.exhausted_after);
        end else begin
          want = expected_results.pop_front();
          if (got.address !== want.address || got.position_valid !== want.position_valid ||
              got.exhausted_after !== want.exhausted_after) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: address %h/%h position_valid %b/%b exhausted_after %b/%b",
                       want.address, got.address, want.position_valid, got.position_valid,
                       want.exhausted_after, got.exhausted_after);
          end
        end
      end
      res_ch.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  initial begin
    int           r;
    int           a;
    int           k;
    int           phase;
    int           random_sent;
    int           walk_len;
    int           n_use;
    int           roll;
    bit           wide;
    bit           prev_cfg;
    logic [2:0]   count_v;
    logic [15:0]  it_f;
    logic [15:0]  st_f;
    logic [63:0]  iter_v;
    logic [63:0]  stor_v;
    logic [AXIS_W-1:0] ax;
    logic         kind;

    mismatches = 0;
    steady     = 1'b0;
    axes_reg   = 3'd1;
    iter_reg   = '0;
    stor_reg   = '0;
    for (a = 0; a < NUM_AXES; a++) cnt_reg[a] = '0;

    rst_n               <= 1'b0;
    cfg_we              <= 1'b0;
    cfg_index           <= CFG_AXIS_COUNT;
    cfg_data            <= '0;
    req_ch.valid        <= 1'b0;
    req_ch.kind         <= KIND_EMIT;
    req_ch.advance_axis <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    prev_cfg = 1'b0;
    for (r = 0; r < NUM_ROWS; r++) begin
      if (DIRECTED_ROWS[r].is_cfg) begin
        if (!prev_cfg) drain();
        set_register(DIRECTED_ROWS[r].cfg_index, DIRECTED_ROWS[r].cfg_value);
      end else begin
        issue(DIRECTED_ROWS[r].kind, DIRECTED_ROWS[r].axis, DIRECTED_ROWS[r].typed,
              DIRECTED_ROWS[r].result);
      end
      prev_cfg = DIRECTED_ROWS[r].is_cfg;
    end

    // random walks: reconfigure, restart, then mostly full odometer steps
    phase       = 0;
    random_sent = 0;
    while (random_sent < RANDOM_ITEMS) begin
      drain();
      steady  = (phase == 4 || phase == 5);
      wide    = (phase % 5 == 3);
      count_v = (phase == 0) ? 3'd0 : (phase == 1) ? 3'd7 : 3'($urandom_range(0, 7));
      if (wide) begin
        iter_v = {$urandom, $urandom};
        stor_v = {$urandom, $urandom};
      end else begin
        for (a = 0; a < NUM_AXES; a++) begin
          it_f = 16'($urandom_range(0, 4));
          case ($urandom_range(0, 3))
            0: st_f = '0;
            1: st_f = it_f;
            2: st_f = 16'($urandom_range(1, 3));
            default: st_f = 16'($urandom);
          endcase
          iter_v[SZ_W*a +: SZ_W] = it_f;
          stor_v[SZ_W*a +: SZ_W] = st_f;
        end
      end
      set_register(CFG_AXIS_COUNT, {61'd0, count_v});
      set_register(CFG_ITER_SIZES, iter_v);
      set_register(CFG_STOR_SIZES, stor_v);
      n_use = axes_in_use();

      issue(KIND_RESTART, 3'($urandom_range(0, 7)), 1'b0, '0);
      walk_len = $urandom_range(10, 50);
      for (k = 0; k < walk_len; k++) begin
        roll = $urandom_range(0, 99);
        kind = KIND_EMIT;
        if (roll < 70) begin
          if ($urandom_range(0, 3) == 0) ax = 3'($urandom_range(n_use - 1, 3));
          else ax = 3'(n_use - 1);
        end else if (roll < 85) begin
          ax = 3'($urandom_range(0, 3));
        end else if (roll < 92) begin
          ax = 3'($urandom_range(4, 7));
        end else begin
          kind = KIND_RESTART;
          ax   = 3'($urandom_range(0, 7));
        end
        issue(kind, ax, 1'b0, '0);
      end
      random_sent += walk_len + 1;
      phase++;
    end

    req_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("nd_address_generator_unit_test: done, clean");
    end else begin
      $display("nd_address_generator_unit_test: done, errors");
    end
    $finish;
  end

endmodule
